// ===== rtl/udpc_pkg.sv =====
// ----------------------------------------------------------------------------
// udpc_pkg
// Types, constants and helpers shared by the UDP datagram checker.
// ----------------------------------------------------------------------------
`default_nettype none

package udpc_pkg;

    localparam int unsigned SumW   = 16;
    localparam int unsigned CountW = 17;

    localparam logic [SumW-1:0]   UdpProtocol    = 16'd17;
    localparam logic [SumW-1:0]   UdpHeaderBytes = 16'd8;
    localparam logic [CountW-1:0] CountLimit     = 17'h1_0000;

    localparam logic [0:0] IpVersionV4 = 1'b0;
    localparam logic [0:0] IpVersionV6 = 1'b1;

    localparam logic [0:0] ActionPseudo   = 1'b0;
    localparam logic [0:0] ActionDatagram = 1'b1;

    typedef enum logic [2:0] {
        VERDICT_OK        = 3'd0,
        VERDICT_TOO_SHORT = 3'd1,
        VERDICT_LEN_BAD   = 3'd2,
        VERDICT_ZERO_CSUM = 3'd3,
        VERDICT_CSUM_BAD  = 3'd4
    } t_verdict;

    typedef struct packed {
        logic       action;
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  verdict;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [15:0] udp_length;
        logic [15:0] checksum_field;
    } t_out_word;

    // ones' complement add with end-around carry
    function automatic logic [SumW-1:0] add_ones(input logic [SumW-1:0] a,
                                                 input logic [SumW-1:0] b);
        logic [SumW:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            add_ones = s[SumW-1:0] + {{(SumW-1){1'b0}}, s[SumW]};
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/udpc_core.sv =====
// ----------------------------------------------------------------------------
// udpc_core
// Running checksum, header capture, byte count and verdict for one datagram.
// ----------------------------------------------------------------------------
`default_nettype none

module udpc_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_step,
    input  wire udpc_pkg::t_in_word i_word,
    input  wire logic               i_ip_version,
    output logic                    o_done,
    output udpc_pkg::t_out_word     o_result
);

    logic [15:0] r_sum,   n_sum;
    logic [7:0]  r_held,  n_held;
    logic        r_odd,   n_odd;
    logic        r_in_dg, n_in_dg;
    logic [16:0] r_count, n_count;
    logic [15:0] r_sport, n_sport;
    logic [15:0] r_dport, n_dport;
    logic [15:0] r_len,   n_len;
    logic [15:0] r_csum,  n_csum;

    // values after this byte, before any clear
    logic [15:0] upd_sum;
    logic [7:0]  upd_held;
    logic        upd_odd;
    logic        upd_in_dg;
    logic [16:0] upd_count;
    logic [15:0] upd_sport;
    logic [15:0] upd_dport;
    logic [15:0] upd_len;
    logic [15:0] upd_csum;
    logic        feed;
    logic        is_dg;

    logic [17:0] total;
    logic [16:0] fold1;
    logic [15:0] final_sum;
    udpc_pkg::t_verdict verdict;

    assign is_dg  = (i_word.action == udpc_pkg::ActionDatagram);
    assign feed   = i_step && (is_dg || !r_in_dg);
    assign o_done = i_step && is_dg && i_word.last_byte;

    always_comb begin
        upd_sum   = r_sum;
        upd_held  = r_held;
        upd_odd   = r_odd;
        upd_in_dg = r_in_dg;
        upd_count = r_count;
        upd_sport = r_sport;
        upd_dport = r_dport;
        upd_len   = r_len;
        upd_csum  = r_csum;
        if (feed) begin
            if (r_odd) begin
                upd_sum = udpc_pkg::add_ones(r_sum, {r_held, i_word.data_byte});
                upd_odd = 1'b0;
            end else begin
                upd_held = i_word.data_byte;
                upd_odd  = 1'b1;
            end
        end
        if (i_step && is_dg) begin
            upd_in_dg = 1'b1;
            case (r_count)
                17'd0: upd_sport = {i_word.data_byte, 8'h00};
                17'd1: upd_sport = {r_sport[15:8], i_word.data_byte};
                17'd2: upd_dport = {i_word.data_byte, 8'h00};
                17'd3: upd_dport = {r_dport[15:8], i_word.data_byte};
                17'd4: upd_len   = {i_word.data_byte, 8'h00};
                17'd5: upd_len   = {r_len[15:8], i_word.data_byte};
                17'd6: upd_csum  = {i_word.data_byte, 8'h00};
                17'd7: upd_csum  = {r_csum[15:8], i_word.data_byte};
                default: ;
            endcase
            if (r_count != udpc_pkg::CountLimit) begin
                upd_count = r_count + 17'd1;
            end
        end
    end

    // pad, protocol and length words summed at once, then folded twice
    always_comb begin
        total = {2'b00, upd_sum}
              + {2'b00, (upd_odd ? {upd_held, 8'h00} : 16'h0000)}
              + {2'b00, udpc_pkg::UdpProtocol}
              + {2'b00, upd_len};
        fold1     = {1'b0, total[15:0]} + {15'd0, total[17:16]};
        final_sum = fold1[15:0] + {15'd0, fold1[16]};
    end

    always_comb begin
        if (upd_count < {1'b0, udpc_pkg::UdpHeaderBytes}) begin
            verdict = udpc_pkg::VERDICT_TOO_SHORT;
        end else if (upd_len < udpc_pkg::UdpHeaderBytes
                     || {1'b0, upd_len} != upd_count) begin
            verdict = udpc_pkg::VERDICT_LEN_BAD;
        end else if (upd_csum == 16'h0000) begin
            verdict = (i_ip_version == udpc_pkg::IpVersionV6)
                    ? udpc_pkg::VERDICT_ZERO_CSUM : udpc_pkg::VERDICT_OK;
        end else if (final_sum != 16'hFFFF) begin
            verdict = udpc_pkg::VERDICT_CSUM_BAD;
        end else begin
            verdict = udpc_pkg::VERDICT_OK;
        end
    end

    always_comb begin
        o_result.verdict        = verdict;
        o_result.src_port       = upd_sport;
        o_result.dst_port       = upd_dport;
        o_result.udp_length     = upd_len;
        o_result.checksum_field = upd_csum;
    end

    // everything clears once the verdict is out
    always_comb begin
        if (o_done) begin
            n_sum   = '0;
            n_held  = '0;
            n_odd   = 1'b0;
            n_in_dg = 1'b0;
            n_count = '0;
            n_sport = '0;
            n_dport = '0;
            n_len   = '0;
            n_csum  = '0;
        end else begin
            n_sum   = upd_sum;
            n_held  = upd_held;
            n_odd   = upd_odd;
            n_in_dg = upd_in_dg;
            n_count = upd_count;
            n_sport = upd_sport;
            n_dport = upd_dport;
            n_len   = upd_len;
            n_csum  = upd_csum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_held  <= '0;
            r_odd   <= 1'b0;
            r_in_dg <= 1'b0;
            r_count <= '0;
            r_sport <= '0;
            r_dport <= '0;
            r_len   <= '0;
            r_csum  <= '0;
        end else begin
            r_sum   <= n_sum;
            r_held  <= n_held;
            r_odd   <= n_odd;
            r_in_dg <= n_in_dg;
            r_count <= n_count;
            r_sport <= n_sport;
            r_dport <= n_dport;
            r_len   <= n_len;
            r_csum  <= n_csum;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/udp_datagram_checker.sv =====
// ----------------------------------------------------------------------------
// udp_datagram_checker
// Receive-side UDP checksum and header check, one byte per word.
// ----------------------------------------------------------------------------
//  channel   | handshake                 | payload
//  ----------+---------------------------+----------------------------------
//  byte in   | i_in_valid / o_in_ready   | i_in_data  (action, byte, last)
//  verdict   | o_out_valid / i_out_ready | o_out_data (verdict, header)
//  config    | i_cfg_we                  | i_cfg_wdata (ip_version)
//
//  one byte per cycle unless a waiting verdict holds the input register;
//  a verdict is registered in the output register as the last byte steps out.
//  the byte rate is set by the combinational sum/capture update in udpc_core.
//  synchronous active-low reset clears core state, ip_version and valid flags.
//  a stalled verdict only holds the input register when it carries a last
//  datagram byte; other bytes keep flowing behind a waiting verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module udp_datagram_checker (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire udpc_pkg::t_in_word  i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output udpc_pkg::t_out_word      o_out_data,
    input  wire logic                i_cfg_we,
    input  wire logic                i_cfg_wdata
);

    logic                r_in_valid;
    udpc_pkg::t_in_word  r_in;
    logic                r_out_valid;
    udpc_pkg::t_out_word r_out;
    logic                r_ip_version;

    logic                out_free;
    logic                ends_dg;
    logic                step;
    logic                done;
    udpc_pkg::t_out_word result;

    assign out_free   = !r_out_valid || i_out_ready;
    assign ends_dg    = (r_in.action == udpc_pkg::ActionDatagram) && r_in.last_byte;
    assign step       = r_in_valid && (!ends_dg || out_free);
    assign o_in_ready = !r_in_valid || step;

    udpc_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_word       (r_in),
        .i_ip_version (r_ip_version),
        .o_done       (done),
        .o_result     (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ip_version <= udpc_pkg::IpVersionV4;
        end else if (i_cfg_we) begin
            r_ip_version <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// ===== tb/udp_datagram_checker_test.sv =====
// ----------------------------------------------------------------------------
// udp_datagram_checker_test
// Self-checking bench for the UDP receive checker. Bytes are driven from a
// queue with random gaps and verdicts are taken with random back-pressure.
// A tracker of the checksum and header capture predicts every verdict, which
// is compared field by field against the block output. Covers both IP modes,
// every verdict, odd pairing, stray and flagged pseudo bytes and a long
// receiver stall that backs up the input.
// ----------------------------------------------------------------------------
module udp_datagram_checker_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int StallLimit   = 2000;
    localparam int HoldCycles   = 300;
    localparam int ItemTarget   = 950;
    localparam int SettleCycles = 4;
    localparam int DrainCycles  = 20;

    typedef enum int {
        FLAW_NONE,
        FLAW_BAD_CSUM,
        FLAW_LEN_WRONG,
        FLAW_TRUNCATED,
        FLAW_ZERO_CSUM,
        FLAW_STRAY_PSEUDO,
        FLAW_PSEUDO_LAST
    } t_flaw;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_ready;
    udpc_pkg::t_in_word  i_in_data   = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    udpc_pkg::t_out_word o_out_data;
    logic                i_cfg_we    = 1'b0;
    logic                i_cfg_wdata = 1'b0;

    udpc_pkg::t_in_word  bytes_to_send[$];
    udpc_pkg::t_out_word verdicts_due[$];

    int   items_queued  = 0;
    int   mismatches    = 0;
    int   stall_cycles  = 0;
    int   send_gap_max  = 5;
    int   sink_gap_max  = 5;
    int   send_wait     = 0;
    int   sink_wait     = 0;
    int   hold_left     = 0;
    bit   sink_hold_req = 1'b0;
    bit   byte_taken    = 1'b0;
    bit   result_taken  = 1'b0;

    // tracker state
    logic        v6_mode;
    logic [15:0] sum_acc;
    logic [7:0]  hi_hold;
    logic        phase_odd;
    logic        in_dgram;
    logic [16:0] dg_count;
    logic [15:0] cap_src;
    logic [15:0] cap_dst;
    logic [15:0] cap_len;
    logic [15:0] cap_csum;

    udp_datagram_checker u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic [15:0] fold_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

    task automatic clear_tracker();
        sum_acc   = '0;
        hi_hold   = '0;
        phase_odd = 1'b0;
        in_dgram  = 1'b0;
        dg_count  = '0;
        cap_src   = '0;
        cap_dst   = '0;
        cap_len   = '0;
        cap_csum  = '0;
    endtask

    task automatic pair_byte(input logic [7:0] b);
        if (phase_odd) begin
            sum_acc   = fold_add(sum_acc, {hi_hold, b});
            phase_odd = 1'b0;
        end else begin
            hi_hold   = b;
            phase_odd = 1'b1;
        end
    endtask

    task automatic take_checker_byte(input udpc_pkg::t_in_word w);
        logic [15:0]         total;
        udpc_pkg::t_out_word res;
        if (w.action == udpc_pkg::ActionPseudo) begin
            // pseudo bytes are dropped once the datagram has started
            if (!in_dgram) pair_byte(w.data_byte);
        end else begin
            in_dgram = 1'b1;
            pair_byte(w.data_byte);
            case (dg_count)
                17'd0: cap_src  = {w.data_byte, 8'h00};
                17'd1: cap_src[7:0]  = w.data_byte;
                17'd2: cap_dst  = {w.data_byte, 8'h00};
                17'd3: cap_dst[7:0]  = w.data_byte;
                17'd4: cap_len  = {w.data_byte, 8'h00};
                17'd5: cap_len[7:0]  = w.data_byte;
                17'd6: cap_csum = {w.data_byte, 8'h00};
                17'd7: cap_csum[7:0] = w.data_byte;
                default: ;
            endcase
            if (dg_count < udpc_pkg::CountLimit) dg_count++;
            if (w.last_byte) begin
                total = sum_acc;
                if (phase_odd) total = fold_add(total, {hi_hold, 8'h00});
                total = fold_add(total, udpc_pkg::UdpProtocol);
                total = fold_add(total, cap_len);
                if (dg_count < 17'(udpc_pkg::UdpHeaderBytes))
                    res.verdict = udpc_pkg::VERDICT_TOO_SHORT;
                else if (cap_len < udpc_pkg::UdpHeaderBytes || 17'(cap_len) != dg_count)
                    res.verdict = udpc_pkg::VERDICT_LEN_BAD;
                else if (cap_csum == 16'h0000)
                    res.verdict = (v6_mode == udpc_pkg::IpVersionV6) ?
                                  udpc_pkg::VERDICT_ZERO_CSUM : udpc_pkg::VERDICT_OK;
                else if (total != 16'hFFFF)
                    res.verdict = udpc_pkg::VERDICT_CSUM_BAD;
                else
                    res.verdict = udpc_pkg::VERDICT_OK;
                res.src_port       = cap_src;
                res.dst_port       = cap_dst;
                res.udp_length     = cap_len;
                res.checksum_field = cap_csum;
                verdicts_due.push_back(res);
                clear_tracker();
            end
        end
    endtask

    task automatic report_field(input string what, input logic [15:0] want,
                                input logic [15:0] got);
        mismatches++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
    endtask

    // monitor and watchdog
    always @(posedge i_clk) begin
        udpc_pkg::t_out_word want;
        byte_taken   = i_rst_n && i_in_valid && o_in_ready;
        result_taken = i_rst_n && o_out_valid && i_out_ready;
        if (result_taken) begin
            if (verdicts_due.size() == 0) begin
                mismatches++;
                $display("%0t: verdict word, expected none, actual %h", $time, o_out_data);
            end else begin
                want = verdicts_due.pop_front();
                if (o_out_data.verdict !== want.verdict)
                    report_field("verdict", 16'(want.verdict), 16'(o_out_data.verdict));
                if (o_out_data.src_port !== want.src_port)
                    report_field("src_port", want.src_port, o_out_data.src_port);
                if (o_out_data.dst_port !== want.dst_port)
                    report_field("dst_port", want.dst_port, o_out_data.dst_port);
                if (o_out_data.udp_length !== want.udp_length)
                    report_field("udp_length", want.udp_length, o_out_data.udp_length);
                if (o_out_data.checksum_field !== want.checksum_field)
                    report_field("checksum_field", want.checksum_field,
                                 o_out_data.checksum_field);
            end
        end
        if (byte_taken) take_checker_byte(i_in_data);
        if (byte_taken || result_taken)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= StallLimit) begin
            $display("%0t: no progress for %0d cycles", $time, StallLimit);
            $display("TB_ERROR");
            $finish;
        end
    end

    // byte driver
    always @(negedge i_clk) begin
        logic vld;
        vld = i_in_valid;
        if (byte_taken) vld = 1'b0;
        if (i_rst_n && !vld && bytes_to_send.size() > 0) begin
            if (send_wait > 0) begin
                send_wait--;
            end else begin
                i_in_data <= bytes_to_send.pop_front();
                vld       = 1'b1;
                send_wait = $urandom_range(0, send_gap_max);
            end
        end
        i_in_valid <= vld;
    end

    // verdict receiver
    always @(negedge i_clk) begin
        logic rdy;
        rdy = i_out_ready;
        if (result_taken) begin
            rdy       = 1'b0;
            sink_wait = $urandom_range(0, sink_gap_max);
        end
        if (sink_hold_req) begin
            sink_hold_req = 1'b0;
            hold_left     = HoldCycles;
        end
        if (hold_left > 0) begin
            hold_left--;
            rdy = 1'b0;
        end else if (!rdy) begin
            if (sink_wait > 0)
                sink_wait--;
            else
                rdy = 1'b1;
        end
        i_out_ready <= rdy;
    end

    task automatic push_word(input logic act, input logic [7:0] b, input logic lst);
        udpc_pkg::t_in_word w;
        w.action    = act;
        w.data_byte = b;
        w.last_byte = lst;
        bytes_to_send.push_back(w);
        items_queued++;
    endtask

    task automatic queue_datagram(input int n_pseudo, input logic [15:0] src,
                                  input logic [15:0] dst, input int payload_len,
                                  input t_flaw flaw);
        logic [7:0]  pseudo[$];
        logic [7:0]  body[$];
        logic [7:0]  all_bytes[$];
        logic [15:0] len_field;
        logic [15:0] sum;
        logic [15:0] csum;
        logic [7:0]  hi;
        int          n;
        int          stray_at;
        int          flag_at;
        for (int i = 0; i < n_pseudo; i++) pseudo.push_back(8'($urandom));
        len_field = 16'(payload_len + 8);
        if (flaw == FLAW_LEN_WRONG)
            len_field = $urandom_range(0, 1) ? 16'($urandom_range(0, 7)) : 16'($urandom);
        body = '{src[15:8], src[7:0], dst[15:8], dst[7:0],
                 len_field[15:8], len_field[7:0], 8'h00, 8'h00};
        for (int i = 0; i < payload_len; i++) body.push_back(8'($urandom));

        // checksum over the pseudo header and datagram in one word stream
        all_bytes = {pseudo, body};
        sum = '0;
        hi  = '0;
        n   = 0;
        foreach (all_bytes[i]) begin
            if (n % 2 == 0)
                hi = all_bytes[i];
            else
                sum = fold_add(sum, {hi, all_bytes[i]});
            n++;
        end
        if (n % 2 != 0) sum = fold_add(sum, {hi, 8'h00});
        sum  = fold_add(sum, udpc_pkg::UdpProtocol);
        sum  = fold_add(sum, len_field);
        csum = ~sum;
        if (csum == 16'h0000) csum = 16'hFFFF;
        if (flaw == FLAW_ZERO_CSUM) csum = 16'h0000;
        if (flaw == FLAW_BAD_CSUM) csum ^= 16'($urandom_range(1, 65535));
        body[6] = csum[15:8];
        body[7] = csum[7:0];
        if (flaw == FLAW_TRUNCATED) begin
            n    = $urandom_range(1, 7);
            body = body[0:n-1];
        end

        flag_at  = (flaw == FLAW_PSEUDO_LAST && n_pseudo > 0) ?
                   $urandom_range(0, n_pseudo - 1) : -1;
        stray_at = (flaw == FLAW_STRAY_PSEUDO) ? $urandom_range(0, body.size() - 2) : -1;
        foreach (pseudo[i]) push_word(udpc_pkg::ActionPseudo, pseudo[i], i == flag_at);
        foreach (body[i]) begin
            push_word(udpc_pkg::ActionDatagram, body[i], i == body.size() - 1);
            if (i == stray_at)
                push_word(udpc_pkg::ActionPseudo, 8'($urandom), 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic queue_random_datagram();
        int    pick;
        int    n_pseudo;
        int    pay;
        t_flaw flaw;
        n_pseudo = (v6_mode == udpc_pkg::IpVersionV6) ? 32 : 8;
        pay      = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 120) :
                   $urandom_range(0, 24);
        pick     = $urandom_range(0, 19);
        flaw     = FLAW_NONE;
        if (pick == 12 || pick == 13) flaw = FLAW_BAD_CSUM;
        else if (pick == 14) flaw = FLAW_LEN_WRONG;
        else if (pick == 15) flaw = FLAW_TRUNCATED;
        else if (pick == 16) flaw = FLAW_ZERO_CSUM;
        else if (pick == 17) flaw = FLAW_STRAY_PSEUDO;
        else if (pick == 18) flaw = FLAW_PSEUDO_LAST;
        else if (pick == 19) n_pseudo = $urandom_range(0, 40);  // pairing shifts when odd
        queue_datagram(n_pseudo, 16'($urandom), 16'($urandom), pay, flaw);
    endtask

    task automatic wait_drained();
        while (bytes_to_send.size() != 0 || i_in_valid || verdicts_due.size() != 0)
            @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic set_ip_version(input logic v6);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v6;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        v6_mode     = v6;
    endtask

    initial begin
        clear_tracker();
        v6_mode = udpc_pkg::IpVersionV4;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed, ipv4
        set_ip_version(udpc_pkg::IpVersionV4);
        queue_datagram(8, 16'hFFFF, 16'h0000, 1, FLAW_NONE);
        queue_datagram(8, 16'h0000, 16'hFFFF, 0, FLAW_BAD_CSUM);
        queue_datagram(0, 16'h1234, 16'h5678, 0, FLAW_TRUNCATED);
        queue_datagram(8, 16'h0035, 16'h0035, 4, FLAW_LEN_WRONG);
        queue_datagram(8, 16'hABCD, 16'h00FF, 3, FLAW_ZERO_CSUM);
        queue_datagram(7, 16'h0101, 16'hFEFE, 2, FLAW_NONE);
        queue_datagram(8, 16'h8000, 16'h7FFF, 5, FLAW_PSEUDO_LAST);
        queue_datagram(8, 16'h00FF, 16'hFF00, 5, FLAW_STRAY_PSEUDO);
        push_word(udpc_pkg::ActionDatagram, 8'hFF, 1'b1);
        wait_drained();

        // directed, ipv6
        set_ip_version(udpc_pkg::IpVersionV6);
        queue_datagram(32, 16'hFFFF, 16'hFFFF, 6, FLAW_NONE);
        queue_datagram(32, 16'h0000, 16'h0000, 2, FLAW_ZERO_CSUM);
        queue_datagram(32, 16'h4000, 16'h0002, 9, FLAW_BAD_CSUM);
        wait_drained();

        // receiver holds off while short datagrams keep coming
        set_ip_version(udpc_pkg::IpVersionV4);
        sink_gap_max  = 0;
        sink_hold_req = 1'b1;
        repeat (20) queue_datagram(0, 16'($urandom), 16'($urandom),
                                   $urandom_range(0, 2), FLAW_NONE);
        wait_drained();

        while (items_queued < ItemTarget) begin
            set_ip_version(1'($urandom_range(0, 1)));
            send_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 5;
            sink_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 5;
            repeat ($urandom_range(4, 10)) queue_random_datagram();
            wait_drained();
        end

        repeat (DrainCycles) @(posedge i_clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== udp_datagram_checker.f =====
rtl/udpc_pkg.sv
rtl/udpc_core.sv
rtl/udp_datagram_checker.sv
tb/udp_datagram_checker_test.sv
